### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the compressor checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: property failed");

`endif

### rtl/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Types, constants and tables shared by the lookahead stereo compressor.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAX_CHUNK   = 64;
  localparam int DEPTH       = 2 * MAX_CHUNK;
  localparam int ADDR_BITS   = $clog2(DEPTH);
  localparam int LEN_BITS    = 7;
  localparam int POS_BITS    = $clog2(MAX_CHUNK);
  localparam int GAIN_BITS   = 24;
  localparam int DIV_NW      = 46;
  localparam int DIV_DW      = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 23;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE  = 24'd8388608;
  localparam logic [GAIN_BITS-1:0] GAIN_HALF = 24'd4194304;
  localparam logic [22:0]          TH_RESET  = 23'd8388524;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMITER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd5;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_MUL_L,
    OP_MUL_R,
    OP_CE_START,
    OP_LATCH_R,
    OP_POW_CHK,
    OP_NORM,
    OP_LOG,
    OP_MLOG,
    OP_M2,
    OP_EXP,
    OP_SHIFT,
    OP_GAIN,
    OP_CHANGE_ATT,
    OP_REL_STEP,
    OP_STEP,
    OP_FINISH_CE,
    OP_OUTPUT
  } op_e;

  typedef enum logic [1:0] {
    BR_ATTACK,
    BR_PENDING,
    BR_RELEASE
  } branch_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] step;
  } cmd_t;

  typedef struct packed {
    logic    chunk_end;
    logic    hit;
    logic    r_zero;
    logic    expo_zero;
    logic    m_norm;
    logic    div_done;
    branch_e branch;
    logic    out_free;
  } stat_t;

  typedef logic [16:0][30:0] exp_tbl_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bitv;
    n    = n_in;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bitv > n) bitv = bitv >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bitv != 0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res;
  endfunction

  // Entry k holds 2^(-2^-k) in Q1.30, each derived from the one before.
  function automatic exp_tbl_t build_exp_tbl();
    exp_tbl_t    t;
    logic [63:0] s;
    t[0] = 31'd536870912;
    for (int k = 1; k <= 16; k++) begin
      s    = isqrt64({3'b0, t[k-1], 30'b0});
      t[k] = s[30:0];
    end
    return t;
  endfunction

  localparam exp_tbl_t EXP_TBL = build_exp_tbl();

  function automatic logic [GAIN_BITS-1:0] clamp_gain(input logic signed [25:0] v);
    if (v < 0) return '0;
    if (v > $signed({2'b0, GAIN_ONE})) return GAIN_ONE;
    return v[GAIN_BITS-1:0];
  endfunction

endpackage

### rtl/lsc_div.sv
// ----------------------------------------------------------------------------
// lsc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [lsc_pkg::DIV_NW-1:0] num_i,
  input  logic [lsc_pkg::DIV_DW-1:0] den_i,
  output logic                      done_o,
  output logic [lsc_pkg::DIV_NW-1:0] quot_o
);
  import lsc_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIV_NW-1:0] quot_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_q, quot_q[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= DIV_DW'(trial - {1'b0, den_q});
      end else begin
        rem_q <= trial[DIV_DW-1:0];
      end
      quot_q <= {quot_q[DIV_NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### rtl/lsc_datapath.sv
// ----------------------------------------------------------------------------
// lsc_datapath
// Delay line, peak tracking, gain arithmetic and the output register.
// ----------------------------------------------------------------------------
module lsc_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lsc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic signed [lsc_pkg::SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [lsc_pkg::SAMPLE_BITS-1:0] right_in_i,
  input  logic                            clear_hits_i,
  input  lsc_pkg::cmd_t                   cmd_i,
  output lsc_pkg::stat_t                  stat_o,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic signed [lsc_pkg::SAMPLE_BITS-1:0] left_out_o,
  output logic signed [lsc_pkg::SAMPLE_BITS-1:0] right_out_o,
  output logic [lsc_pkg::GAIN_BITS-1:0]   gain_applied_o,
  output logic [31:0]                     hit_count_o
);
  import lsc_pkg::*;

  localparam int SW = SAMPLE_BITS;

  // Configuration registers.
  logic [22:0]         th_q;
  logic [LEN_BITS-1:0] len_cfg_q;
  logic                lim_q;
  logic [15:0]         expo_q;
  logic [15:0]         att_cfg_q;
  logic [15:0]         rel_cfg_q;

  // Control state.
  logic [ADDR_BITS-1:0]   wr_pos_q;
  logic [POS_BITS-1:0]    pos_q;
  logic [SW-1:0]          peak_q;
  logic [GAIN_BITS-1:0]   gain_now_q;
  logic signed [24:0]     gain_step_q;
  logic [GAIN_BITS-1:0]   last_target_q;
  logic [GAIN_BITS-1:0]   release_step_q;
  logic                   pending_q;
  logic [31:0]            hits_q;
  logic [GAIN_BITS-1:0]   ramp_q;
  logic [DEPTH-1:0]       entry_valid_q;
  logic                   end_q;
  logic                   out_valid_q;

  // Payload registers.
  logic [2*SW-1:0]        mem [DEPTH];
  logic [2*SW-1:0]        rdata_q;
  logic                   rvalid_q;
  logic [GAIN_BITS-1:0]   g_q;
  logic                   clear_q;
  logic [SW-1:0]          lo_q;
  logic [SW-1:0]          ro_q;
  logic [22:0]            r_q;
  logic [GAIN_BITS-1:0]   target_q;
  logic [23:0]            m_q;
  logic [4:0]             cnt_q;
  logic [15:0]            frac_q;
  logic [20:0]            mlog_q;
  logic [20:0]            m2_q;
  logic [30:0]            x_q;
  logic signed [24:0]     change_q;
  logic                   neg_q;
  logic signed [SW-1:0]   left_out_q;
  logic signed [SW-1:0]   right_out_q;
  logic [GAIN_BITS-1:0]   gain_out_q;
  logic [31:0]            hit_out_q;

  // Effective settings.
  logic [LEN_BITS-1:0] len_eff;
  logic [15:0]         att_eff;
  logic [15:0]         rel_eff;
  logic [15:0]         expo_eff;

  always_comb begin
    if (len_cfg_q == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (len_cfg_q > LEN_BITS'(MAX_CHUNK)) begin
      len_eff = LEN_BITS'(MAX_CHUNK);
    end else begin
      len_eff = len_cfg_q;
    end
    att_eff  = lim_q ? 16'd256 : ((att_cfg_q < 16'd256) ? 16'd256 : att_cfg_q);
    rel_eff  = (rel_cfg_q < 16'd256) ? 16'd256 : rel_cfg_q;
    expo_eff = lim_q ? 16'd0 : expo_q;
  end

  // Capture-side arithmetic.
  logic [ADDR_BITS-1:0] rd_addr;
  logic [SW-1:0]        abs_l;
  logic [SW-1:0]        abs_r;
  logic [SW-1:0]        peak_new;
  logic [POS_BITS:0]    pos_next;

  assign rd_addr  = wr_pos_q - ADDR_BITS'({len_eff, 1'b0});
  assign abs_l    = left_in_i[SW-1] ? SW'(-left_in_i) : SW'(left_in_i);
  assign abs_r    = right_in_i[SW-1] ? SW'(-right_in_i) : SW'(right_in_i);
  assign pos_next = {1'b0, pos_q} + 1'b1;

  always_comb begin
    peak_new = peak_q;
    if (abs_l > peak_new) peak_new = abs_l;
    if (abs_r > peak_new) peak_new = abs_r;
  end

  // Output scaling: one multiplier, used for left then right.
  logic signed [SW-1:0]   sel_sample;
  logic signed [2*SW:0]   scale_prod;

  always_comb begin
    if (!rvalid_q) begin
      sel_sample = '0;
    end else if (cmd_i.op == OP_MUL_R) begin
      sel_sample = rdata_q[SW-1:0];
    end else begin
      sel_sample = rdata_q[2*SW-1:SW];
    end
  end

  assign scale_prod = sel_sample * $signed({1'b0, g_q});

  // Power arithmetic.
  logic [47:0] sq_prod;
  logic [24:0] sq;
  logic [37:0] m2_prod;
  logic [4:0]  tbl_idx;
  logic [61:0] exp_prod;
  logic [4:0]  ip;
  logic [4:0]  sh;
  logic [30:0] x_shifted;

  assign sq_prod   = m_q * m_q;
  assign sq        = sq_prod[47:23];
  assign m2_prod   = mlog_q * (17'd65536 - {1'b0, expo_eff});
  assign tbl_idx   = {1'b0, cmd_i.step} + 5'd1;
  assign exp_prod  = x_q * EXP_TBL[tbl_idx];
  assign ip        = m2_q[20:16];
  assign sh        = ip + 5'd7;
  assign x_shifted = x_q >> sh;

  // Gain branch and release candidate.
  branch_e     branch;
  logic [24:0] rel_sum;
  logic [24:0] rel_t;
  logic [23:0] change_mag;

  always_comb begin
    if (target_q <= gain_now_q) begin
      branch = BR_ATTACK;
    end else if (pending_q) begin
      branch = BR_PENDING;
    end else begin
      branch = BR_RELEASE;
    end
    rel_sum = {1'b0, gain_now_q} + {1'b0, release_step_q};
    rel_t   = rel_sum;
    if ({1'b0, last_target_q} < rel_t) rel_t = {1'b0, last_target_q};
    if ({1'b0, target_q} < rel_t) rel_t = {1'b0, target_q};
    change_mag = change_q[24] ? 24'(-change_q) : change_q[23:0];
  end

  // Shared divider.
  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_done;
  logic [DIV_NW-1:0] div_quot;
  logic              hit;

  assign hit = peak_q > {1'b0, th_q};

  always_comb begin
    div_start = 1'b0;
    div_num   = {th_q, 23'b0};
    div_den   = peak_q;
    case (cmd_i.op)
      OP_CE_START: begin
        div_start = hit;
      end
      OP_GAIN: begin
        if (branch == BR_ATTACK) begin
          div_start = 1'b1;
          div_num   = {14'b0, gain_now_q - target_q, 8'b0};
          div_den   = {8'b0, att_eff};
        end else if (branch == BR_PENDING) begin
          div_start = 1'b1;
          div_num   = {14'b0, GAIN_ONE - last_target_q, 8'b0};
          div_den   = {8'b0, rel_eff};
        end
      end
      OP_STEP: begin
        div_start = 1'b1;
        div_num   = {22'b0, change_mag};
        div_den   = {17'b0, len_eff};
      end
      default: begin
      end
    endcase
  end

  lsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  logic signed [24:0] step_val;
  logic signed [25:0] gain_sum;
  logic signed [25:0] ramp_sum;

  assign step_val = neg_q ? -$signed({1'b0, div_quot[23:0]}) : $signed({1'b0, div_quot[23:0]});
  assign gain_sum = $signed({2'b0, gain_now_q}) + 26'(change_q);
  assign ramp_sum = $signed({2'b0, ramp_q}) + 26'(gain_step_q);

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_q           <= TH_RESET;
      len_cfg_q      <= LEN_BITS'(16);
      lim_q          <= 1'b0;
      expo_q         <= '0;
      att_cfg_q      <= 16'd256;
      rel_cfg_q      <= 16'd4096;
      wr_pos_q       <= '0;
      pos_q          <= '0;
      peak_q         <= {1'b0, TH_RESET};
      gain_now_q     <= '0;
      gain_step_q    <= '0;
      last_target_q  <= GAIN_HALF;
      release_step_q <= '0;
      pending_q      <= 1'b1;
      hits_q         <= '0;
      ramp_q         <= '0;
      entry_valid_q  <= '0;
      end_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_THRESHOLD: th_q      <= cfg_data_i;
          CFG_CHUNK_LEN: len_cfg_q <= cfg_data_i[LEN_BITS-1:0];
          CFG_LIMITER:   lim_q     <= cfg_data_i[0];
          CFG_EXPONENT:  expo_q    <= cfg_data_i[15:0];
          CFG_ATTACK:    att_cfg_q <= cfg_data_i[15:0];
          CFG_RELEASE:   rel_cfg_q <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.op == OP_OUTPUT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CAPTURE: begin
          entry_valid_q[wr_pos_q] <= 1'b1;
          wr_pos_q <= wr_pos_q + 1'b1;
          ramp_q   <= clamp_gain(ramp_sum);
          peak_q   <= peak_new;
          if (pos_next >= (POS_BITS+1)'(len_eff)) begin
            pos_q <= '0;
            end_q <= 1'b1;
          end else begin
            pos_q <= pos_next[POS_BITS-1:0];
            end_q <= 1'b0;
          end
        end
        OP_CE_START: begin
          if (hit && (hits_q != '1)) hits_q <= hits_q + 1'b1;
        end
        OP_GAIN: begin
          if (branch == BR_ATTACK) begin
            pending_q <= 1'b1;
          end else if (branch == BR_PENDING) begin
            pending_q <= 1'b0;
          end
        end
        OP_REL_STEP: begin
          release_step_q <= div_quot[23:0];
        end
        OP_FINISH_CE: begin
          gain_step_q   <= step_val;
          ramp_q        <= gain_now_q;
          gain_now_q    <= clamp_gain(gain_sum);
          last_target_q <= target_q;
          peak_q        <= {1'b0, th_q};
        end
        OP_OUTPUT: begin
          if (clear_q) hits_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        // The read sees the entry before this transfer overwrites it.
        rdata_q       <= mem[rd_addr];
        rvalid_q      <= entry_valid_q[rd_addr];
        mem[wr_pos_q] <= {left_in_i, right_in_i};
        g_q           <= ramp_q;
        clear_q       <= clear_hits_i;
      end
      OP_MUL_L: lo_q <= scale_prod[2*SW-2:SW-1];
      OP_MUL_R: ro_q <= scale_prod[2*SW-2:SW-1];
      OP_CE_START: begin
        if (!hit) target_q <= GAIN_ONE;
      end
      OP_LATCH_R: r_q <= div_quot[22:0];
      OP_POW_CHK: begin
        if (r_q == '0) begin
          target_q <= '0;
        end else if (expo_eff == '0) begin
          target_q <= {1'b0, r_q};
        end
        m_q    <= {1'b0, r_q};
        cnt_q  <= '0;
        frac_q <= '0;
      end
      OP_NORM: begin
        if (!m_q[23]) begin
          m_q   <= {m_q[22:0], 1'b0};
          cnt_q <= cnt_q + 1'b1;
        end
      end
      OP_LOG: begin
        if (sq[24]) begin
          m_q    <= sq[24:1];
          frac_q <= {frac_q[14:0], 1'b1};
        end else begin
          m_q    <= sq[23:0];
          frac_q <= {frac_q[14:0], 1'b0};
        end
      end
      OP_MLOG: mlog_q <= {cnt_q, 16'b0} - {5'b0, frac_q};
      OP_M2: begin
        m2_q <= m2_prod[36:16];
        x_q  <= 31'h4000_0000;
      end
      OP_EXP: begin
        if (m2_q[4'd15 - cmd_i.step]) x_q <= exp_prod[60:30];
      end
      OP_SHIFT: begin
        target_q <= (ip >= 5'd24) ? '0 : x_shifted[GAIN_BITS-1:0];
      end
      OP_GAIN: begin
        if (branch == BR_PENDING) begin
          change_q <= '0;
        end else if (branch == BR_RELEASE) begin
          change_q <= $signed(rel_t) - $signed({1'b0, gain_now_q});
        end
      end
      OP_CHANGE_ATT: change_q <= -$signed({1'b0, div_quot[23:0]});
      OP_STEP: neg_q <= change_q[24];
      OP_OUTPUT: begin
        left_out_q  <= lo_q;
        right_out_q <= ro_q;
        gain_out_q  <= g_q;
        hit_out_q   <= hits_q;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.chunk_end = end_q;
  assign stat_o.hit       = hit;
  assign stat_o.r_zero    = (r_q == '0);
  assign stat_o.expo_zero = (expo_eff == '0);
  assign stat_o.m_norm    = m_q[23];
  assign stat_o.div_done  = div_done;
  assign stat_o.branch    = branch;
  assign stat_o.out_free  = out_free;

  assign out_valid_o    = out_valid_q;
  assign left_out_o     = left_out_q;
  assign right_out_o    = right_out_q;
  assign gain_applied_o = gain_out_q;
  assign hit_count_o    = hit_out_q;

endmodule

### rtl/lsc_ctrl.sv
// ----------------------------------------------------------------------------
// lsc_ctrl
// Sequencer for sample transfer, chunk-end gain computation and output.
// ----------------------------------------------------------------------------
module lsc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lsc_pkg::stat_t stat_i,
  output lsc_pkg::cmd_t  cmd_o
);
  import lsc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_L,
    S_MUL_R,
    S_CE_START,
    S_DIV_R,
    S_POW_CHK,
    S_NORM,
    S_LOG,
    S_MLOG,
    S_M2,
    S_EXP,
    S_SHIFT,
    S_GAIN,
    S_DIV_C,
    S_DIV_REL,
    S_STEP,
    S_DIV_S,
    S_FINISH
  } state_e;

  state_e     state_q;
  logic [3:0] step_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.step = step_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) cmd_o.op = OP_CAPTURE;
      S_MUL_L:    cmd_o.op = OP_MUL_L;
      S_MUL_R:    cmd_o.op = OP_MUL_R;
      S_CE_START: cmd_o.op = OP_CE_START;
      S_DIV_R:    if (stat_i.div_done) cmd_o.op = OP_LATCH_R;
      S_POW_CHK:  cmd_o.op = OP_POW_CHK;
      S_NORM:     cmd_o.op = OP_NORM;
      S_LOG:      cmd_o.op = OP_LOG;
      S_MLOG:     cmd_o.op = OP_MLOG;
      S_M2:       cmd_o.op = OP_M2;
      S_EXP:      cmd_o.op = OP_EXP;
      S_SHIFT:    cmd_o.op = OP_SHIFT;
      S_GAIN:     cmd_o.op = OP_GAIN;
      S_DIV_C:    if (stat_i.div_done) cmd_o.op = OP_CHANGE_ATT;
      S_DIV_REL:  if (stat_i.div_done) cmd_o.op = OP_REL_STEP;
      S_STEP:     cmd_o.op = OP_STEP;
      S_DIV_S:    if (stat_i.div_done) cmd_o.op = OP_FINISH_CE;
      S_FINISH:   if (stat_i.out_free) cmd_o.op = OP_OUTPUT;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_MUL_L;
        S_MUL_L: state_q <= S_MUL_R;
        S_MUL_R: state_q <= stat_i.chunk_end ? S_CE_START : S_FINISH;
        S_CE_START: state_q <= stat_i.hit ? S_DIV_R : S_GAIN;
        S_DIV_R: if (stat_i.div_done) state_q <= S_POW_CHK;
        S_POW_CHK: begin
          if (stat_i.r_zero || stat_i.expo_zero) begin
            state_q <= S_GAIN;
          end else begin
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          // The shift only happens while the top bit is clear.
          if (stat_i.m_norm) begin
            state_q <= S_LOG;
            step_q  <= '0;
          end
        end
        S_LOG: begin
          step_q <= step_q + 1'b1;
          if (step_q == 4'd15) state_q <= S_MLOG;
        end
        S_MLOG: state_q <= S_M2;
        S_M2: begin
          state_q <= S_EXP;
          step_q  <= '0;
        end
        S_EXP: begin
          step_q <= step_q + 1'b1;
          if (step_q == 4'd15) state_q <= S_SHIFT;
        end
        S_SHIFT: state_q <= S_GAIN;
        S_GAIN: begin
          case (stat_i.branch)
            BR_ATTACK:  state_q <= S_DIV_C;
            BR_PENDING: state_q <= S_DIV_REL;
            default:    state_q <= S_STEP;
          endcase
        end
        S_DIV_C:   if (stat_i.div_done) state_q <= S_STEP;
        S_DIV_REL: if (stat_i.div_done) state_q <= S_STEP;
        S_STEP:    state_q <= S_DIV_S;
        S_DIV_S:   if (stat_i.div_done) state_q <= S_FINISH;
        S_FINISH:  if (stat_i.out_free) state_q <= S_IDLE;
        default:   state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/lookahead_stereo_compressor.sv
// ----------------------------------------------------------------------------
// lookahead_stereo_compressor
// Output: out_valid_o rises once S_FINISH loads the output register; a
// transfer that closes a chunk first runs up to three divider passes.
// Throughput: one sample at a time; in_stall_o stays high until the sequencer
// is back in idle, also while an output stall holds it in S_FINISH.
// Reset: asynchronous; the delay line reads as zero through valid bits.
// ----------------------------------------------------------------------------
module lookahead_stereo_compressor (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [lsc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [lsc_pkg::SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [lsc_pkg::SAMPLE_BITS-1:0] right_in_i,
  input  logic                                  clear_hits_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [lsc_pkg::SAMPLE_BITS-1:0] left_out_o,
  output logic signed [lsc_pkg::SAMPLE_BITS-1:0] right_out_o,
  output logic [lsc_pkg::GAIN_BITS-1:0]         gain_applied_o,
  output logic [31:0]                           hit_count_o
);
  import lsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lsc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .left_in_i      (left_in_i),
    .right_in_i     (right_in_i),
    .clear_hits_i   (clear_hits_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .gain_applied_o (gain_applied_o),
    .hit_count_o    (hit_count_o)
  );

endmodule

### rtl/lsc_checker.sv
// ----------------------------------------------------------------------------
// lsc_checker
// Port-level checks for the lookahead stereo compressor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsc_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [lsc_pkg::SAMPLE_BITS-1:0] left_out_o,
  input logic signed [lsc_pkg::SAMPLE_BITS-1:0] right_out_o,
  input logic [lsc_pkg::GAIN_BITS-1:0]         gain_applied_o,
  input logic [31:0]                           hit_count_o
);
  import lsc_pkg::*;

  logic         out_held;
  logic [103:0] res_w;

  assign out_held = out_valid_o && out_stall_i;
  assign res_w    = {left_out_o, right_out_o, gain_applied_o, hit_count_o};

  // A transfer starts work on one sample, so the input must be busy next.
  `LSC_ASSERT_NXT(a_busy_after_transfer, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A stalled result keeps its value.
  `LSC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(res_w))

  // The reported gain never exceeds unity.
  `LSC_ASSERT_IMPL(a_gain_range, clk_i, rst_ni, out_valid_o, gain_applied_o <= GAIN_ONE)

endmodule

bind lookahead_stereo_compressor lsc_checker u_lsc_checker (.*);

### test/lookahead_stereo_compressor_tb.sv
// ----------------------------------------------------------------------------
// lookahead_stereo_compressor_tb
// Self-checking bench for the lookahead compressor. A scoreboard class keeps
// its own bit-true copy of the peak tracking, gain computation and delay
// line, and predicts each output transfer. Both handshakes see random gaps
// and stalls. Register settings change between phases, with every transfer
// drained before each write.
// ----------------------------------------------------------------------------
module lookahead_stereo_compressor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsc_pkg::*;

  typedef struct {
    logic [23:0] left;
    logic [23:0] right;
    logic [23:0] gain;
    logic [31:0] hits;
  } sample_out_t;

  class gain_scoreboard;
    longint        dly_l[128];
    longint        dly_r[128];
    longint        peak, gain_now, gain_step, last_tgt, rel_step, ramp;
    bit            rel_pending;
    int unsigned   pos, wr;
    longint unsigned hit_cnt;
    longint        th, clen, lim, expo, att_cfg, rel_cfg;
    sample_out_t   expected_out[$];
    int            errors;

    function new();
      for (int i = 0; i < 128; i++) begin
        dly_l[i] = 0;
        dly_r[i] = 0;
      end
      th = 8388524; clen = 16; lim = 0; expo = 0; att_cfg = 256; rel_cfg = 4096;
      peak = th; pos = 0; gain_now = 0; gain_step = 0; last_tgt = 4194304;
      rel_step = 0; rel_pending = 1; hit_cnt = 0; wr = 0; ramp = 0; errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned v);
      case (idx)
        CFG_THRESHOLD: th = v & 64'h7FFFFF;
        CFG_CHUNK_LEN: clen = v & 64'h7F;
        CFG_LIMITER:   lim = v & 1;
        CFG_EXPONENT:  expo = v & 64'hFFFF;
        CFG_ATTACK:    att_cfg = v & 64'hFFFF;
        CFG_RELEASE:   rel_cfg = v & 64'hFFFF;
        default: ;
      endcase
    endfunction

    function longint clampg(longint g);
      if (g < 0) return 0;
      if (g > 8388608) return 8388608;
      return g;
    endfunction

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Gain (th/peak)^(1-exponent) through a base-2 log and exp in fixed point.
    function longint target_gain(longint unsigned r, longint unsigned ex);
      longint unsigned tbl[17];
      longint unsigned m, frac, mlog, m2, ip, f, x;
      int p;
      if (r == 0) return 0;
      if (ex == 0) return longint'(r);
      p = 0;
      frac = 0;
      while (p < 22 && (r >> (p + 1)) != 0) p++;
      m = r << (23 - p);
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 23;
        frac = frac << 1;
        if (m >= (64'd1 << 24)) begin
          m = m >> 1;
          frac = frac | 1;
        end
      end
      mlog = longint'(23 - p) * 65536 - frac;
      m2 = (mlog * (65536 - ex)) >> 16;
      ip = m2 >> 16;
      f = m2 & 16'hFFFF;
      tbl[0] = 64'd1 << 29;
      for (int k = 1; k <= 16; k++) tbl[k] = root_floor(tbl[k-1] << 30);
      x = 64'd1 << 30;
      for (int k = 1; k <= 16; k++)
        if ((f >> (16 - k)) & 1) x = (x * tbl[k]) >> 30;
      if (ip >= 24) return 0;
      return longint'(x >> (7 + ip));
    endfunction

    function void close_chunk(longint len);
      longint tgt, prev, change, t, att, rel;
      prev = gain_now;
      if (peak > th) begin
        if (hit_cnt != 64'hFFFF_FFFF) hit_cnt++;
        tgt = target_gain((th << 23) / peak, lim ? 0 : expo);
      end else begin
        tgt = 8388608;
      end
      att = lim ? 256 : (att_cfg < 256 ? 256 : att_cfg);
      rel = rel_cfg < 256 ? 256 : rel_cfg;
      if (tgt <= prev) begin
        rel_pending = 1;
        change = ((tgt - prev) * 256) / att;
      end else if (rel_pending) begin
        change = 0;
        rel_pending = 0;
        rel_step = ((8388608 - last_tgt) * 256) / rel;
      end else begin
        t = prev + rel_step;
        if (last_tgt < t) t = last_tgt;
        if (tgt < t) t = tgt;
        change = t - prev;
      end
      gain_step = change / len;
      ramp = prev;
      gain_now = clampg(prev + change);
      last_tgt = tgt;
      peak = th;
    endfunction

    function void note_sample(logic signed [23:0] l_in, logic signed [23:0] r_in, bit clr);
      longint len, l, r, g, al, ar;
      int unsigned rd;
      sample_out_t e;
      len = (clen == 0) ? 1 : (clen > 64 ? 64 : clen);
      l = l_in;
      r = r_in;
      rd = (wr + 128 - 2 * len) % 128;
      g = clampg(ramp);
      e.left = (dly_l[rd] * g) >>> 23;
      e.right = (dly_r[rd] * g) >>> 23;
      e.gain = g[23:0];
      dly_l[wr] = l;
      dly_r[wr] = r;
      wr = (wr + 1) % 128;
      ramp = clampg(ramp + gain_step);
      al = l < 0 ? -l : l;
      ar = r < 0 ? -r : r;
      if (al > peak) peak = al;
      if (ar > peak) peak = ar;
      pos++;
      if (pos >= len) begin
        close_chunk(len);
        pos = 0;
      end
      e.hits = hit_cnt[31:0];
      if (clr) hit_cnt = 0;
      expected_out.push_back(e);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_output(logic [23:0] l, logic [23:0] r, logic [23:0] g, logic [31:0] h);
      sample_out_t e;
      if (expected_out.size() == 0) begin
        report("unexpected transfer", 0, 0);
      end else begin
        e = expected_out.pop_front();
        if (l !== e.left) report("left_out", l, e.left);
        if (r !== e.right) report("right_out", r, e.right);
        if (g !== e.gain) report("gain_applied", g, e.gain);
        if (h !== e.hits) report("hit_count", h, e.hits);
      end
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic signed [SAMPLE_BITS-1:0] left_in_i = '0;
  logic signed [SAMPLE_BITS-1:0] right_in_i = '0;
  logic clear_hits_i = 0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic signed [SAMPLE_BITS-1:0] left_out_o, right_out_o;
  logic [GAIN_BITS-1:0] gain_applied_o;
  logic [31:0] hit_count_o;

  lookahead_stereo_compressor dut (.*);

  gain_scoreboard sb = new();
  bit no_gaps;
  int quiet_cycles;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Any handshake or register write restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("lookahead_stereo_compressor_tb failed");
      $finish;
    end
  end

  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      @(negedge clk_i);
      if (gap > 0) begin
        out_stall_i <= 1;
        repeat (gap) @(negedge clk_i);
        out_stall_i <= 0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      sb.check_output(left_out_o, right_out_o, gain_applied_o, hit_count_o);
    end
  end

  task send_sample(logic signed [23:0] l, logic signed [23:0] r, bit clr);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    left_in_i <= l;
    right_in_i <= r;
    clear_hits_i <= clr;
    in_valid_i <= 1;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    sb.note_sample(l, r, clr);
  endtask

  // Holds off the sender until every expected transfer has come back.
  task drain;
    @(negedge clk_i);
    in_valid_i <= 0;
    while (sb.expected_out.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned v);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= v[CFG_DATA_W-1:0];
    sb.write_reg(idx, v);
  endtask

  task run_phase(longint unsigned th, longint unsigned len, longint unsigned lim,
                 longint unsigned ex, longint unsigned att, longint unsigned rel, int n);
    int kind;
    logic signed [23:0] l, r, lvl;
    write_reg(CFG_THRESHOLD, th);
    write_reg(CFG_CHUNK_LEN, len);
    write_reg(CFG_LIMITER, lim);
    write_reg(CFG_EXPONENT, ex);
    write_reg(CFG_ATTACK, att);
    write_reg(CFG_RELEASE, rel);
    @(negedge clk_i);
    cfg_we_i <= 0;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      // Loud bursts push the gain down; quiet stretches let it release.
      if (kind < 4) begin
        l = $urandom;
        r = $urandom;
      end else if (kind < 7) begin
        lvl = $urandom_range(0, 65535);
        l = $signed(lvl) - 32768;
        r = $urandom_range(0, 65535) - 32768;
      end else begin
        l = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
        r = $urandom_range(0, 1) ? -l : l;
      end
      send_sample(l, r, $urandom_range(0, 9) == 0);
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    no_gaps = 0;
    // Directed: full-scale extremes, zero, sign mix and hit clearing.
    for (int i = 0; i < 6; i++) send_sample(24'sh7FFFFF, 24'sh800000, 0);
    for (int i = 0; i < 6; i++) send_sample(24'sh000000, 24'sh000001, 0);
    send_sample(24'sh800000, 24'sh7FFFFF, 1);
    send_sample(24'shFFFFFF, 24'sh000000, 0);
    for (int i = 0; i < 10; i++) send_sample(24'sh800000, 24'sh800000, i == 9);
    drain();
    run_phase(8388607, 1, 0, 65535, 65535, 65535, 60);
    run_phase(0, 4, 0, 32768, 256, 256, 80);
    run_phase(4000000, 64, 1, 12345, 1000, 2000, 260);
    run_phase(1000000, 0, 0, 0, 0, 0, 60);
    run_phase(2000000, 127, 0, 40000, 255, 300, 200);
    run_phase(8388524, 16, 0, 0, 256, 4096, 60);
    for (int p = 0; p < 3; p++)
      run_phase($urandom_range(0, 8388607), $urandom_range(1, 12), $urandom_range(0, 1),
                $urandom_range(0, 65535), $urandom_range(256, 2000),
                $urandom_range(256, 5000), 50);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0)
      $display("lookahead_stereo_compressor_tb passed");
    else
      $display("lookahead_stereo_compressor_tb failed");
    $finish;
  end
endmodule
